### rtl/core/record_dedup_table_assert.svh
// Assertion macros used by the record_dedup_table sequencer (rdt_seq).
`ifndef RECORD_DEDUP_TABLE_ASSERT_SVH
`define RECORD_DEDUP_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RDT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/rdt_pkg.sv
// Package: types, sizes and state codes of the record dedup table.
`timescale 1ns / 1ps
package rdt_pkg;

   localparam int TABLE_DEPTH   = 2048;
   localparam int INDEX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_INDEX_W = 11;

   typedef struct packed {
      logic               action;
      logic signed [15:0] floor_height;
      logic signed [15:0] ceiling_height;
      logic [63:0]        floor_texture;
      logic [63:0]        ceiling_texture;
      logic signed [15:0] light_level;
      logic signed [15:0] special_type;
      logic signed [15:0] tag_number;
   } rdt_req_type;

   typedef struct packed {
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic                     was_added;
      logic                     table_full;
   } rdt_rsp_type;

   // One stored record, compared as raw bits.
   typedef struct packed {
      logic [15:0] floor_height;
      logic [15:0] ceiling_height;
      logic [63:0] floor_texture;
      logic [63:0] ceiling_texture;
      logic [15:0] light_level;
      logic [15:0] special_type;
      logic [15:0] tag_number;
   } rdt_record_type;

   typedef struct packed {
      logic               wr_en;
      logic [INDEX_W-1:0] wr_addr;
      logic               rd_en;
      logic [INDEX_W-1:0] rd_addr;
   } rdt_mem_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } rdt_state_type;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

endpackage

### rtl/core/rdt_store.sv
// Record memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rdt_store (
   input  logic                     clock,
   input  rdt_pkg::rdt_mem_cmd_type mem_cmd,
   input  rdt_pkg::rdt_record_type  wr_data,
   output rdt_pkg::rdt_record_type  rd_data
);
   import rdt_pkg::*;

   rdt_record_type mem [TABLE_DEPTH];
   rdt_record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[mem_cmd.wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem[mem_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rdt_match.sv
// Shared compare unit: full-record equality of the search key and a stored entry.
`timescale 1ns / 1ps
module rdt_match (
   input  rdt_pkg::rdt_record_type key,
   input  rdt_pkg::rdt_record_type entry,
   output logic                    hit
);
   import rdt_pkg::*;

   always_comb begin
      hit = (key.floor_height    == entry.floor_height)    &&
            (key.ceiling_height  == entry.ceiling_height)  &&
            (key.floor_texture   == entry.floor_texture)   &&
            (key.ceiling_texture == entry.ceiling_texture) &&
            (key.light_level     == entry.light_level)     &&
            (key.special_type    == entry.special_type)    &&
            (key.tag_number      == entry.tag_number);
   end

endmodule

### rtl/core/rdt_seq.sv
// Search sequencer: clear, or walk entries and append on miss; drive result.
`timescale 1ns / 1ps
`include "record_dedup_table_assert.svh"
module rdt_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  rdt_pkg::rdt_req_type     req_word,
   output logic                     rsp_strobe,
   output rdt_pkg::rdt_rsp_type     rsp_word,
   input  logic                     hit,
   output rdt_pkg::rdt_record_type  key,
   output rdt_pkg::rdt_mem_cmd_type mem_cmd
);
   import rdt_pkg::*;

   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(TABLE_DEPTH);

   rdt_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   issue_ff, issue_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [INDEX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rdt_rsp_type          rsp_word_ff, rsp_word_in;
   rdt_record_type       key_ff, key_in;
   logic                 accept;
   logic                 found;
   logic                 scan_end;

   assign accept   = start && (state_ff == ST_IDLE);
   assign found    = chk_valid_ff && hit;
   assign scan_end = (issue_ff == count_ff) && !found;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_word.action == ACT_LOOKUP)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (found || scan_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in     = count_ff;
      issue_in     = issue_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      key_in       = key_ff;
      mem_cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_word.action == ACT_CLEAR) begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '0;
               end else begin
                  issue_in               = '0;
                  key_in.floor_height    = req_word.floor_height;
                  key_in.ceiling_height  = req_word.ceiling_height;
                  key_in.floor_texture   = req_word.floor_texture;
                  key_in.ceiling_texture = req_word.ceiling_texture;
                  key_in.light_level     = req_word.light_level;
                  key_in.special_type    = req_word.special_type;
                  key_in.tag_number      = req_word.tag_number;
               end
            end
         end
         ST_SCAN: begin
            if (found) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.entry_index = ENTRY_INDEX_W'(chk_idx_ff);
               rsp_word_in.was_added   = 1'b0;
               rsp_word_in.table_full  = 1'b0;
            end else if (scan_end) begin
               rsp_valid_in = 1'b1;
               if (count_ff == DEPTH_COUNT) begin
                  rsp_word_in.entry_index = '0;
                  rsp_word_in.was_added   = 1'b0;
                  rsp_word_in.table_full  = 1'b1;
               end else begin
                  mem_cmd.wr_en           = 1'b1;
                  mem_cmd.wr_addr         = count_ff[INDEX_W-1:0];
                  count_in                = count_ff + 1'b1;
                  rsp_word_in.entry_index = ENTRY_INDEX_W'(count_ff[INDEX_W-1:0]);
                  rsp_word_in.was_added   = 1'b1;
                  rsp_word_in.table_full  = 1'b0;
               end
            end else if (issue_ff != count_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = issue_ff[INDEX_W-1:0];
               chk_valid_in    = 1'b1;
               chk_idx_in      = issue_ff[INDEX_W-1:0];
               issue_in        = issue_ff + 1'b1;
            end
         end
         default: begin
            chk_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      rsp_word_ff <= rsp_word_in;
      key_ff      <= key_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign key        = key_ff;

   `RDT_ASSERT_NOW(a_count_range, clock, reset, 1'b1, count_ff <= DEPTH_COUNT,
      "entry count above table depth")
   `RDT_ASSERT_NOW(a_write_room, clock, reset, mem_cmd.wr_en, count_ff < DEPTH_COUNT,
      "append into a full table")
   `RDT_ASSERT_NEXT(a_clear_empties, clock, reset, accept && (req_word.action == ACT_CLEAR),
      (count_ff == '0) && rsp_valid_ff, "clear did not empty the table")
   `RDT_ASSERT_NEXT(a_scan_result, clock, reset, (state_ff == ST_SCAN) && (found || scan_end),
      rsp_valid_ff && (state_ff == ST_IDLE), "search end without a result")
   `RDT_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_valid_ff,
      !(rsp_word_ff.was_added && rsp_word_ff.table_full), "added and full together")

endmodule

### rtl/core/record_dedup_table.sv
// Top level of the record dedup table: lookup-or-insert over stored area records.
`timescale 1ns / 1ps
//
//   channel   ports                        handshake
//   request   start, busy, req_word        taken when start && !busy
//   result    rsp_strobe, rsp_word         one cycle, cannot be held off
//
// A clear word is handled in the cycle it is accepted; its result strobes on the next cycle.
// A lookup word walks the stored entries through one memory read port,
// one entry per cycle, and ends at the first hit or, after the last of the N
// stored entries, with an append or a table-full result (a full table
// holds 2048 entries).
// Synchronous reset empties the table at once; no clearing pass is needed.
// busy stays high for the whole search; results are never stalled.
module record_dedup_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rdt_pkg::rdt_req_type req_word,
   output logic                 rsp_strobe,
   output rdt_pkg::rdt_rsp_type rsp_word
);
   import rdt_pkg::*;

   rdt_mem_cmd_type mem_cmd;
   rdt_record_type  key;
   rdt_record_type  rd_data;
   logic            hit;

   // Sequencer: holds the key, advances the read pointer, decides hit,
   // append or full, and drives the result word.
   rdt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .hit        (hit),
      .key        (key),
      .mem_cmd    (mem_cmd)
   );

   // Record store: the append writes the key at the current count while
   // the search reads one entry per cycle with registered data.
   rdt_store u_store (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .wr_data (key),
      .rd_data (rd_data)
   );

   // Shared compare unit: checks the entry read last cycle against the key.
   rdt_match u_match (
      .key   (key),
      .entry (rd_data),
      .hit   (hit)
   );

endmodule
